/* hw/rtl/integer_divider_signed_unsigned_assert.svh */
// assertion macros used by the checker file
`ifndef INTEGER_DIVIDER_SIGNED_UNSIGNED_ASSERT_SVH
`define INTEGER_DIVIDER_SIGNED_UNSIGNED_ASSERT_SVH

// plain concurrent check, disabled while reset is asserted
`define IDSU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// a value must hold on the cycle after cond
`define IDSU_ASSERT_STABLE(lbl, clk, rst_n, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

/* hw/rtl/idsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package idsu_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DATA_W);

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic store;
	} cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/idsu_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface idsu_req_if;
	import idsu_pkg::*;

	logic  valid;
	logic  ready;
	logic  action;
	word_t dividend;
	word_t divisor;

	modport source(output valid, action, dividend, divisor, input ready);
	modport sink(input valid, action, dividend, divisor, output ready);

endinterface

`default_nettype wire

/* hw/rtl/idsu_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface idsu_rsp_if;
	import idsu_pkg::*;

	logic  valid;
	logic  ready;
	word_t quotient;
	word_t remainder;

	modport source(output valid, quotient, remainder, input ready);
	modport sink(input valid, quotient, remainder, output ready);

endinterface

`default_nettype wire

/* hw/rtl/idsu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module idsu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output idsu_pkg::cmd_t     cmd
);
	import idsu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX
	} state_t;

	state_t state_q;
	cnt_t   cnt_q;
	logic   rsp_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	assign cmd.load  = req_valid && req_ready;
	assign cmd.step  = (state_q == ST_DIV);
	// the output register is free when empty or drained in this cycle
	assign cmd.store = (state_q == ST_FIX) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DATA_W - 1)) begin
						state_q <= ST_FIX;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_FIX: begin
					if (cmd.store) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.store) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/idsu_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module idsu_dpath (
	input  wire logic            clk,
	input  wire idsu_pkg::cmd_t  cmd,
	input  wire logic            action,
	input  wire idsu_pkg::word_t dividend,
	input  wire idsu_pkg::word_t divisor,
	output idsu_pkg::word_t      quotient,
	output idsu_pkg::word_t      remainder
);
	import idsu_pkg::*;

	word_t rem_q;
	word_t qn_q;       // dividend bits shift out, quotient bits shift in
	word_t den_q;
	logic  neg_quo_q;
	logic  neg_rem_q;
	logic  zero_q;
	word_t quo_out_q;
	word_t rem_out_q;

	logic            dvd_neg;
	logic            dvs_neg;
	word_t           rem_sh;
	logic [DATA_W:0] diff;
	logic            take;

	assign dvd_neg = action && dividend[DATA_W-1];
	assign dvs_neg = action && divisor[DATA_W-1];

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh = {rem_q[DATA_W-2:0], qn_q[DATA_W-1]};
	assign diff   = {1'b0, rem_sh} - {1'b0, den_q};
	assign take   = rem_q[DATA_W-1] || !diff[DATA_W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qn_q      <= dvd_neg ? ({DATA_W{1'b0}} - dividend) : dividend;
			den_q     <= dvs_neg ? ({DATA_W{1'b0}} - divisor) : divisor;
			rem_q     <= '0;
			neg_quo_q <= dvd_neg ^ dvs_neg;
			neg_rem_q <= dvd_neg;
			zero_q    <= (divisor == '0);
		end else if (cmd.step) begin
			rem_q <= take ? diff[DATA_W-1:0] : rem_sh;
			qn_q  <= {qn_q[DATA_W-2:0], take};
		end

		// with a zero divisor the remainder already ends up as the dividend
		if (cmd.store) begin
			if (zero_q) begin
				quo_out_q <= '0;
			end else begin
				quo_out_q <= neg_quo_q ? ({DATA_W{1'b0}} - qn_q) : qn_q;
			end
			rem_out_q <= neg_rem_q ? ({DATA_W{1'b0}} - rem_q) : rem_q;
		end
	end

	assign quotient  = quo_out_q;
	assign remainder = rem_out_q;

endmodule

`default_nettype wire

/* hw/rtl/integer_divider_signed_unsigned.sv */
// 32-bit integer divider, unsigned or signed two's complement.
// req channel: action (0 unsigned, 1 signed), dividend, divisor.
// rsp channel: quotient and remainder, one item per request item.
// Signed quotients truncate toward zero, the remainder takes the sign of the
// dividend, the most negative value by minus one wraps, and a zero divisor
// gives quotient 0 with the dividend as remainder.
// The restoring loop resolves one quotient bit per cycle, then the sign
// fix-up writes the result into the output register behind rsp.valid.
// req.ready is high only while the divider loop is idle, and it takes one
// item at a time.
// A finished result waits in the output register; the next item can be
// accepted and divided meanwhile, and its fix-up cycle holds until the
// receiver takes the waiting result.
// Reset (arst_n low) empties the output register and returns the controller
// to idle; no result is lost or repeated across a stall.
`timescale 1ns / 1ps
`default_nettype none

module integer_divider_signed_unsigned (
	input  wire logic  clk,
	input  wire logic  arst_n,
	idsu_req_if.sink   req,
	idsu_rsp_if.source rsp
);
	import idsu_pkg::*;

	cmd_t  cmd;
	logic  req_ready;
	logic  rsp_valid;
	word_t quotient;
	word_t remainder;

	idsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	idsu_dpath u_dpath (
		.clk       (clk),
		.cmd       (cmd),
		.action    (req.action),
		.dividend  (req.dividend),
		.divisor   (req.divisor),
		.quotient  (quotient),
		.remainder (remainder)
	);

	assign req.ready     = req_ready;
	assign rsp.valid     = rsp_valid;
	assign rsp.quotient  = quotient;
	assign rsp.remainder = remainder;

endmodule

`default_nettype wire

/* hw/rtl/idsu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "integer_divider_signed_unsigned_assert.svh"

module idsu_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_valid,
	input wire logic            req_ready,
	input wire logic            rsp_valid,
	input wire logic            rsp_ready,
	input wire idsu_pkg::word_t rsp_quotient,
	input wire idsu_pkg::word_t rsp_remainder
);
	import idsu_pkg::*;

	logic req_fire;
	logic rsp_stall;

	assign req_fire  = req_valid && req_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;

	`IDSU_ASSERT(a_rsp_hold, clk, arst_n, rsp_stall |=> rsp_valid, "rsp item dropped while stalled")
	`IDSU_ASSERT_STABLE(a_rsp_quo_stable, clk, arst_n, rsp_stall, rsp_quotient, "quotient moved while stalled")
	`IDSU_ASSERT(a_one_in_flight, clk, arst_n, req_fire |=> !req_ready, "item taken while dividing")
	`IDSU_ASSERT(a_loop_busy, clk, arst_n, req_fire |-> ##32 !req_ready, "divider loop ended early")

	// remainder is checked for the stall case only with a valid result
	`IDSU_ASSERT_STABLE(a_rsp_rem_stable, clk, arst_n, rsp_stall, rsp_remainder, "remainder moved while stalled")

endmodule

bind integer_divider_signed_unsigned idsu_checker u_idsu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_quotient  (rsp.quotient),
	.rsp_remainder (rsp.remainder)
);

`default_nettype wire

/* verif/tb_integer_divider_signed_unsigned.sv */
`timescale 1ns / 1ps

module tb_integer_divider_signed_unsigned;
	import idsu_pkg::*;

	typedef enum logic {
		DIV_UNSIGNED = 1'b0,
		DIV_SIGNED   = 1'b1
	} div_mode_e;

	typedef struct packed {
		word_t quotient;
		word_t remainder;
	} div_result_t;

	typedef struct packed {
		div_mode_e mode;
		word_t     dividend;
		word_t     divisor;
		logic      known;
		word_t     quotient;
		word_t     remainder;
	} div_case_t;

	localparam int N_DIRECTED   = 23;
	localparam int N_PER_PHASE  = 100;
	localparam int N_PHASES     = 4;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_REPORTED = 10;

	localparam word_t MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam word_t MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t ALL_ONES = {DATA_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	idsu_req_if req_ch ();
	idsu_rsp_if rsp_ch ();

	integer_divider_signed_unsigned i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	div_result_t pending_results[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	// known answers where they are obvious, the rest goes through the predictor
	div_case_t directed_cases [N_DIRECTED] = '{
		'{DIV_UNSIGNED, '0, '0, 1'b1, '0, '0},
		'{DIV_UNSIGNED, ALL_ONES, '0, 1'b1, '0, ALL_ONES},
		'{DIV_SIGNED, MOST_NEG, '0, 1'b1, '0, MOST_NEG},
		'{DIV_UNSIGNED, ALL_ONES, 32'd1, 1'b1, ALL_ONES, '0},
		'{DIV_UNSIGNED, ALL_ONES, ALL_ONES, 1'b1, 32'd1, '0},
		'{DIV_UNSIGNED, '0, ALL_ONES, 1'b1, '0, '0},
		'{DIV_UNSIGNED, MOST_NEG, ALL_ONES, 1'b1, '0, MOST_NEG},
		'{DIV_SIGNED, MOST_NEG, ALL_ONES, 1'b1, MOST_NEG, '0},
		'{DIV_SIGNED, MOST_NEG, 32'd1, 1'b1, MOST_NEG, '0},
		'{DIV_SIGNED, MOST_NEG, MOST_NEG, 1'b1, 32'd1, '0},
		'{DIV_SIGNED, MOST_POS, ALL_ONES, 1'b1, 32'h8000_0001, '0},
		'{DIV_SIGNED, MOST_POS, MOST_NEG, 1'b1, '0, MOST_POS},
		'{DIV_SIGNED, 32'hFFFF_FFF9, 32'd2, 1'b1, 32'hFFFF_FFFD, ALL_ONES},
		'{DIV_SIGNED, 32'd7, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFD, 32'd1},
		'{DIV_SIGNED, 32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b1, 32'd3, ALL_ONES},
		'{DIV_UNSIGNED, 32'd100, 32'd7, 1'b1, 32'd14, 32'd2},
		'{DIV_SIGNED, ALL_ONES, ALL_ONES, 1'b1, 32'd1, '0},
		'{DIV_UNSIGNED, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'd2, '0},
		'{DIV_SIGNED, MOST_NEG, MOST_POS, 1'b0, '0, '0},
		'{DIV_UNSIGNED, 32'hDEAD_BEEF, 32'h0001_2345, 1'b0, '0, '0},
		'{DIV_SIGNED, 32'hDEAD_BEEF, 32'h0001_2345, 1'b0, '0, '0},
		'{DIV_SIGNED, 32'h1234_5678, 32'hFFFF_0001, 1'b0, '0, '0},
		'{DIV_UNSIGNED, 32'h8000_0001, 32'd3, 1'b0, '0, '0}
	};

	// shift-and-subtract on magnitudes, then sign fix-up
	function automatic div_result_t divide_expect(div_mode_e mode, word_t a, word_t b);
		logic        neg_a;
		logic        neg_b;
		logic        carry;
		word_t       num;
		word_t       den;
		word_t       quo;
		word_t       rem;
		div_result_t res;
		neg_a = (mode == DIV_SIGNED) && a[DATA_W-1];
		neg_b = (mode == DIV_SIGNED) && b[DATA_W-1];
		num = neg_a ? -a : a;
		den = neg_b ? -b : b;
		quo = '0;
		rem = '0;
		if (den == '0) begin
			rem = num;
		end else begin
			for (int i = DATA_W - 1; i >= 0; i--) begin
				carry = rem[DATA_W-1];
				rem = {rem[DATA_W-2:0], num[i]};
				if (carry || rem >= den) begin
					rem = rem - den;
					quo[i] = 1'b1;
				end
			end
		end
		if (neg_a != neg_b)
			quo = -quo;
		if (neg_a)
			rem = -rem;
		res.quotient = quo;
		res.remainder = rem;
		return res;
	endfunction

	function automatic word_t pick_operand();
		word_t v;
		case ($urandom_range(7))
			0, 1: v = word_t'($urandom);
			2: v = word_t'($urandom_range(255));
			3: v = -word_t'($urandom_range(1, 255));
			4: v = word_t'(1) << $urandom_range(DATA_W - 1);
			5: v = MOST_NEG | word_t'($urandom_range(3));
			6: v = MOST_POS ^ word_t'($urandom_range(3));
			default: v = word_t'($urandom) >> $urandom_range(DATA_W - 1);
		endcase
		return v;
	endfunction

	task automatic send_division(input div_mode_e mode, input word_t a, input word_t b,
			input logic known, input word_t q, input word_t r);
		int          gap;
		div_result_t res;
		gap = 0;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
			gap = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= mode;
		req_ch.dividend <= a;
		req_ch.divisor <= b;
		do
			@(posedge clk);
		while (!req_ch.ready);
		if (known) begin
			res.quotient = q;
			res.remainder = r;
		end else begin
			res = divide_expect(mode, a, b);
		end
		pending_results.push_back(res);
	endtask

	initial begin : receiver
		int   hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			// one long stall so the divider fills up and backs up its input
			if (!hold_done && results_seen >= 40) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		div_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTED)
					$display("unexpected result: quotient %h remainder %h",
						rsp_ch.quotient, rsp_ch.remainder);
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.quotient !== want.quotient || rsp_ch.remainder !== want.remainder) begin
					mismatches++;
					if (mismatches <= MAX_REPORTED)
						$display("mismatch: quotient exp %h got %h, remainder exp %h got %h",
							want.quotient, rsp_ch.quotient, want.remainder, rsp_ch.remainder);
				end
			end
		end
	end

	initial begin : stimulus
		div_mode_e mode;
		word_t     a;
		word_t     b;
		req_ch.valid = 1'b0;
		req_ch.action = DIV_UNSIGNED;
		req_ch.dividend = '0;
		req_ch.divisor = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_division(directed_cases[i].mode, directed_cases[i].dividend,
				directed_cases[i].divisor, directed_cases[i].known,
				directed_cases[i].quotient, directed_cases[i].remainder);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int n = 0; n < N_PER_PHASE; n++) begin
				mode = div_mode_e'($urandom_range(1));
				a = pick_operand();
				// zero divisors now and then, otherwise same operand mix
				b = ($urandom_range(19) == 0) ? '0 : pick_operand();
				send_division(mode, a, b, 1'b0, '0, '0);
			end
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
